### src/rm15_min_distance_decoder_assert.svh
// Assertion macros for the RM(1,5) decoder checks.
`ifndef RM15_MIN_DISTANCE_DECODER_ASSERT_SVH
`define RM15_MIN_DISTANCE_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RM15_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rm15 check failed: same-cycle rule");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RM15_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rm15 check failed: next-cycle rule");

`endif

### src/rm15_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rm15_pkg;

  localparam int CodeLen = 32;
  localparam int LogLen  = 5;
  localparam int MsgW    = 6;
  localparam int DistW   = 5;
  localparam int CorrW   = 7;
  localparam int KeyW    = DistW + MsgW;

  typedef logic signed [CorrW-1:0] corr_t;
  typedef corr_t [CodeLen-1:0]     corr_vec_t;
  typedef logic [KeyW-1:0]         key_t;

  localparam corr_t            CorrOne = corr_t'(1);
  localparam logic [DistW-1:0] DistMax = DistW'(CodeLen / 2);

  // Rebuild the message from the linear part and the complement bit.
  function automatic logic [MsgW-1:0] msg_of(input logic [LogLen-1:0] u, input logic c6);
    logic [MsgW-1:0] m;
    m[5] = c6;
    m[4] = u[0] ^ m[5];
    m[3] = u[1] ^ m[4];
    m[2] = u[2] ^ m[3];
    m[1] = u[3] ^ m[2];
    m[0] = u[4] ^ m[1];
    return m;
  endfunction

endpackage

`default_nettype wire

### src/rm15_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rm15_in_if;
  logic                         valid;
  logic                         ready;
  logic [rm15_pkg::CodeLen-1:0] received_word;

  modport source (output valid, output received_word, input ready);
  modport sink   (input valid, input received_word, output ready);
endinterface

`default_nettype wire

### src/rm15_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rm15_out_if;
  logic                       valid;
  logic                       ready;
  logic [rm15_pkg::MsgW-1:0]  message_value;
  logic [rm15_pkg::DistW-1:0] best_distance;

  modport source (output valid, output message_value, output best_distance, input ready);
  modport sink   (input valid, input message_value, input best_distance, output ready);
endinterface

`default_nettype wire

### src/rm15_fht.sv
`timescale 1ns / 1ps
`default_nettype none

module rm15_fht (
  input  logic [rm15_pkg::CodeLen-1:0] word_i,
  output rm15_pkg::corr_vec_t          corr_o
);

  rm15_pkg::corr_vec_t st [rm15_pkg::LogLen+1];

  for (genvar gj = 0; gj < rm15_pkg::CodeLen; gj++) begin : g_init
    assign st[0][gj] = word_i[gj] ? -rm15_pkg::CorrOne : rm15_pkg::CorrOne;
  end

  for (genvar gs = 0; gs < rm15_pkg::LogLen; gs++) begin : g_stage
    for (genvar gj = 0; gj < rm15_pkg::CodeLen; gj++) begin : g_bfly
      localparam int Partner = gj ^ (1 << gs);
      if (((gj >> gs) & 1) == 0) begin : g_sum
        assign st[gs+1][gj] = st[gs][gj] + st[gs][Partner];
      end else begin : g_diff
        assign st[gs+1][gj] = st[gs][Partner] - st[gs][gj];
      end
    end
  end

  assign corr_o = st[rm15_pkg::LogLen];

endmodule

`default_nettype wire

### src/rm15_min_sel.sv
`timescale 1ns / 1ps
`default_nettype none

module rm15_min_sel (
  input  rm15_pkg::corr_vec_t         corr_i,
  output logic [rm15_pkg::MsgW-1:0]   msg_o,
  output logic [rm15_pkg::DistW-1:0]  dist_o
);

  localparam int Nodes = 2 * rm15_pkg::CodeLen - 1;
  localparam int Inner = rm15_pkg::CodeLen - 1;

  rm15_pkg::key_t node [Nodes];

  // Leaves: best of the codeword and its complement; the complement loses a tie.
  for (genvar gu = 0; gu < rm15_pkg::CodeLen; gu++) begin : g_leaf
    logic                       neg;
    rm15_pkg::corr_t            mag;
    logic [rm15_pkg::DistW-1:0] leaf_dist;
    assign neg       = corr_i[gu][rm15_pkg::CorrW-1];
    assign mag       = neg ? -corr_i[gu] : corr_i[gu];
    assign leaf_dist = rm15_pkg::DistMax - mag[rm15_pkg::DistW:1];
    assign node[Inner+gu] = {leaf_dist, rm15_pkg::msg_of(rm15_pkg::LogLen'(gu), neg)};
  end

  // Distance in the upper bits, message below: the smaller key is the winner.
  for (genvar gk = 0; gk < Inner; gk++) begin : g_node
    assign node[gk] = (node[2*gk+1] <= node[2*gk+2]) ? node[2*gk+1] : node[2*gk+2];
  end

  assign dist_o = node[0][rm15_pkg::KeyW-1:rm15_pkg::MsgW];
  assign msg_o  = node[0][rm15_pkg::MsgW-1:0];

endmodule

`default_nettype wire

### src/rm15_min_distance_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// RM(1,5) maximum-likelihood decoder. Each received 32-bit word is compared
// against all 64 first-order Reed-Muller codewords; the block returns the
// 6-bit message of the nearest one (lowest message on a tie) and its Hamming
// distance, 0 to 16. A new word is taken every cycle while ready is high: the
// 5-stage fast Hadamard transform works out of the input register and fills
// the correlation register with all 32 correlations, and the comparison tree
// then picks the winner into the result register.
// Words are independent; there is no state and no configuration. A stall on
// the output holds the pipeline and drops ready only once every stage is full.
module rm15_min_distance_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  rm15_in_if.sink            rx_i,
  rm15_out_if.source         dec_o
);

  logic                         v0_q, v1_q, v2_q;
  logic                         adv0, adv1, adv2;
  logic [rm15_pkg::CodeLen-1:0] word_q;
  rm15_pkg::corr_vec_t          corr_d, corr_q;
  logic [rm15_pkg::MsgW-1:0]    msg_d, msg_q;
  logic [rm15_pkg::DistW-1:0]   dist_d, dist_q;

  assign adv2 = !v2_q || dec_o.ready;
  assign adv1 = !v1_q || adv2;
  assign adv0 = !v0_q || adv1;

  rm15_fht u_fht (
    .word_i (word_q),
    .corr_o (corr_d)
  );

  rm15_min_sel u_min_sel (
    .corr_i (corr_q),
    .msg_o  (msg_d),
    .dist_o (dist_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv0) begin
        v0_q <= rx_i.valid;
      end
      if (adv1) begin
        v1_q <= v0_q;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0 && rx_i.valid) begin
      word_q <= rx_i.received_word;
    end
    if (adv1 && v0_q) begin
      corr_q <= corr_d;
    end
    if (adv2 && v1_q) begin
      msg_q  <= msg_d;
      dist_q <= dist_d;
    end
  end

  assign rx_i.ready          = adv0;
  assign dec_o.valid         = v2_q;
  assign dec_o.message_value = msg_q;
  assign dec_o.best_distance = dist_q;

endmodule

`default_nettype wire

### src/rm15_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "rm15_min_distance_decoder_assert.svh"

module rm15_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rx_valid_i,
  input logic                       rx_ready_i,
  input logic                       dec_valid_i,
  input logic                       dec_ready_i,
  input logic [rm15_pkg::MsgW-1:0]  dec_msg_i,
  input logic [rm15_pkg::DistW-1:0] dec_dist_i
);

  `RM15_ASSERT_NEXT(a_dec_valid_hold, dec_valid_i && !dec_ready_i, dec_valid_i)
  `RM15_ASSERT_NEXT(a_dec_word_hold, dec_valid_i && !dec_ready_i, $stable(dec_msg_i) && $stable(dec_dist_i))
  `RM15_ASSERT_NOW(a_rx_stall_cause, rx_valid_i && !rx_ready_i, dec_valid_i && !dec_ready_i)
  `RM15_ASSERT_NOW(a_dist_bound, dec_valid_i, dec_dist_i <= rm15_pkg::DistMax)

endmodule

bind rm15_min_distance_decoder rm15_chk u_rm15_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rx_valid_i  (rx_i.valid),
  .rx_ready_i  (rx_i.ready),
  .dec_valid_i (dec_o.valid),
  .dec_ready_i (dec_o.ready),
  .dec_msg_i   (dec_o.message_value),
  .dec_dist_i  (dec_o.best_distance)
);

`default_nettype wire

### test/tb_rm15_min_distance_decoder.sv
`timescale 1ns / 1ps

module tb_rm15_min_distance_decoder;

  localparam int NumDirected   = 17;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 16;

  typedef struct packed {
    logic [rm15_pkg::CodeLen-1:0] word;
    logic [rm15_pkg::MsgW-1:0]    msg;
    logic [rm15_pkg::DistW-1:0]   distance;
  } decode_t;

  typedef struct packed {
    logic [rm15_pkg::CodeLen-1:0] word;
    bit                           typed;
    logic [rm15_pkg::MsgW-1:0]    msg;
    logic [rm15_pkg::DistW-1:0]   distance;
  } vector_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rm15_in_if  rx_if ();
  rm15_out_if dec_if ();

  rm15_min_distance_decoder uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .dec_o (dec_if)
  );

  decode_t pending_decodes[$];
  int      mismatch_count = 0;
  int      quiet_cycles   = 0;
  int      src_idle_pct   = 0;
  int      sink_idle_pct  = 0;

  // codewords: affine functions of the position bits; bit-typed expectation only
  // where the answer is obvious (codewords, light errors, one tie)
  vector_row_t directed_rows [NumDirected] = '{
    '{32'h0000_0000, 1'b1, 6'd0,  5'd0},
    '{32'hFFFF_FFFF, 1'b1, 6'd63, 5'd0},
    '{32'h0000_0001, 1'b1, 6'd0,  5'd1},
    '{32'h8000_0000, 1'b1, 6'd0,  5'd1},
    '{32'h7FFF_FFFF, 1'b1, 6'd63, 5'd1},
    '{32'hFFFF_0000, 1'b1, 6'd1,  5'd0},
    '{32'h0000_FFFF, 1'b1, 6'd62, 5'd0},
    '{32'h5555_5555, 1'b1, 6'd32, 5'd0},
    '{32'hAAAA_AAAA, 1'b1, 6'd31, 5'd0},
    '{32'h0000_007F, 1'b1, 6'd0,  5'd7},
    '{32'h00FF_0000, 1'b1, 6'd0,  5'd8},
    '{32'h7888_7888, 1'b0, 6'd0,  5'd0},
    '{32'h0000_00FF, 1'b0, 6'd0,  5'd0},
    '{32'hFFFF_00FF, 1'b0, 6'd0,  5'd0},
    '{32'h0F0F_0F0F, 1'b0, 6'd0,  5'd0},
    '{32'h1234_5678, 1'b0, 6'd0,  5'd0},
    '{32'hDEAD_BEEF, 1'b0, 6'd0,  5'd0}
  };

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [rm15_pkg::CodeLen-1:0] rm_codeword(
    input logic [rm15_pkg::MsgW-1:0] m);
    logic [rm15_pkg::CodeLen-1:0] w;
    w = m[5] ? '1 : '0;
    if (m[5] ^ m[4]) w ^= 32'hAAAA_AAAA;
    if (m[4] ^ m[3]) w ^= 32'hCCCC_CCCC;
    if (m[3] ^ m[2]) w ^= 32'hF0F0_F0F0;
    if (m[2] ^ m[1]) w ^= 32'hFF00_FF00;
    if (m[1] ^ m[0]) w ^= 32'hFFFF_0000;
    return w;
  endfunction

  function automatic decode_t nearest_message(input logic [rm15_pkg::CodeLen-1:0] word);
    decode_t best;
    int      best_d;
    int      d;
    best_d        = rm15_pkg::CodeLen + 1;
    best.word     = word;
    best.msg      = '0;
    best.distance = '0;
    for (int m = 0; m < 64; m++) begin
      d = $countones(rm_codeword(rm15_pkg::MsgW'(m)) ^ word);
      if (d < best_d) begin
        best_d        = d;
        best.msg      = rm15_pkg::MsgW'(m);
        best.distance = rm15_pkg::DistW'(d);
      end
    end
    return best;
  endfunction

  // mostly codewords with a few flipped bits, the rest raw noise
  function automatic logic [rm15_pkg::CodeLen-1:0] random_received_word();
    logic [rm15_pkg::CodeLen-1:0] w;
    int                           flips;
    if ($urandom_range(99) < 65) begin
      w     = rm_codeword(rm15_pkg::MsgW'($urandom_range(63)));
      flips = ($urandom_range(3) == 0) ? $urandom_range(16) : $urandom_range(7);
      repeat (flips) w[$urandom_range(rm15_pkg::CodeLen - 1)] ^= 1'b1;
    end else begin
      w = $urandom;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_word(input logic [rm15_pkg::CodeLen-1:0] word, input decode_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid         <= 1'b1;
    rx_if.received_word <= word;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    pending_decodes.push_back(want);
  endtask

  // hold the sender until every pending word has come back
  task automatic drain_pending();
    rx_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_decodes.size() != 0);
  endtask

  task automatic run_random(input int count, input int src_pct, input int sink_pct);
    logic [rm15_pkg::CodeLen-1:0] w;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) begin
      w = random_received_word();
      send_word(w, nearest_message(w));
    end
  endtask

  always @(posedge clk_i) begin
    dec_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    decode_t want;
    if (dec_if.valid && dec_if.ready) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch($sformatf("unexpected result msg %0d dist %0d",
                                  dec_if.message_value, dec_if.best_distance));
      end else begin
        want = pending_decodes.pop_front();
        if (dec_if.message_value !== want.msg)
          report_mismatch($sformatf("word %h: message_value %0d, want %0d",
                                    want.word, dec_if.message_value, want.msg));
        if (dec_if.best_distance !== want.distance)
          report_mismatch($sformatf("word %h: best_distance %0d, want %0d",
                                    want.word, dec_if.best_distance, want.distance));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (dec_if.valid && dec_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no progress in %0d cycles", WatchdogLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    decode_t want;
    rst_ni              <= 1'b0;
    rx_if.valid         <= 1'b0;
    rx_if.received_word <= '0;
    src_idle_pct  = 11;
    sink_idle_pct = 53;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        want.word     = directed_rows[i].word;
        want.msg      = directed_rows[i].msg;
        want.distance = directed_rows[i].distance;
      end else begin
        want = nearest_message(directed_rows[i].word);
      end
      send_word(directed_rows[i].word, want);
    end
    drain_pending();

    run_random(550, 11, 53);
    drain_pending();
    run_random(550, 53, 11);
    drain_pending();
    run_random(550, 0, 0);
    drain_pending();
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
